// File: design/dtq_pkg.sv
// dtq_pkg: shared constants and types of the delta timer queue.
// No dependencies; imported by dtq_cell, delta_timer_queue, dtq_fire_checker and the testbench.
`timescale 1ns / 1ps

package dtq_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int IDX_W      = $clog2(NUM_TIMERS);
   localparam int PTR_W      = $clog2(NUM_TIMERS + 1);
   localparam int ID_W       = 4;
   localparam int DELTA_W    = 32;
   localparam int SUM_W      = DELTA_W + PTR_W;
   localparam int CD_W       = 28;
   localparam int TIE_W      = 16;
   localparam int MODE_W     = 2;
   localparam int ADDR_W     = 3;

   localparam logic [TIE_W-1:0] TIE_RESET = TIE_W'(80);
   localparam logic [CD_W-1:0]  CD_MAX    = {CD_W{1'b1}};

   // register byte addresses
   localparam logic [ADDR_W-1:0] ADDR_TIE  = ADDR_W'(0);
   localparam logic [ADDR_W-1:0] ADDR_IDLE = ADDR_W'(4);

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK    = 2'd0,
      MODE_INSTALL = 2'd1,
      MODE_REMOVE  = 2'd2,
      MODE_SET_IV  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CELL_NOP    = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_POP    = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic                valid;
      logic [ID_W-1:0]     id;
      logic [DELTA_W-1:0]  delta;
   } entry_type;

   typedef struct packed {
      cell_op_type         op;
      logic [PTR_W-1:0]    pos;     // insert position
      entry_type           fresh;   // entry to insert
      logic [ID_W-1:0]     target;  // id to remove
   } cell_cmd_type;

endpackage

// File: design/dtq_cell.sv
// dtq_cell: one slot of the sorted delta list; shifts with its neighbors.
// Depends on dtq_pkg.
`timescale 1ns / 1ps

module dtq_cell
   import dtq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [PTR_W-1:0] cell_index,
   input  cell_cmd_type     cmd,
   input  entry_type        left,
   input  entry_type        right,
   input  logic             seen_in,
   output logic             seen_out,
   output entry_type        entry
);

   entry_type              entry_ff, entry_in;
   logic                   match;
   logic [DELTA_W:0]       merged;
   logic [PTR_W-1:0]       next_pos;

   assign match    = entry_ff.valid && (entry_ff.id == cmd.target);
   assign seen_out = seen_in || match;
   assign merged   = {1'b0, right.delta} + {1'b0, entry_ff.delta};
   assign next_pos = cmd.pos + PTR_W'(1);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (cell_index == cmd.pos) begin
               entry_in = cmd.fresh;
            end else if (cell_index == next_pos) begin
               entry_in = left;
               // old occupant of the slot now sits behind the new entry
               entry_in.delta = (left.delta >= cmd.fresh.delta) ?
                                left.delta - cmd.fresh.delta : '0;
            end else if (cell_index > cmd.pos) begin
               entry_in = left;
            end
         end
         CELL_REMOVE: begin
            if (match) begin
               entry_in = right;
               if (right.valid)
                  entry_in.delta = merged[DELTA_W] ? '1 : merged[DELTA_W-1:0];
            end else if (seen_in) begin
               entry_in = right;
            end
         end
         CELL_POP: entry_in = right;
         default:  entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.id    <= entry_in.id;
      entry_ff.delta <= entry_in.delta;
   end

endmodule

// File: design/delta_timer_queue.sv
// delta_timer_queue: timer queue built as a chain of delta-list cells.
// Depends on dtq_pkg and dtq_cell.
// Sequence: tick, remove and set interval finish from idle. Install of an unlisted timer
//   walks the cell chain, one cell per cycle, then inserts.
//   Firing tick: pop, the same walk if periodic, then reload of the countdown.
// Requests: one word at a time; req_stall holds them during walk and reload and while a fired word is stalled.
// Reset (synchronous): list empty, countdown all ones, registers at defaults.
`timescale 1ns / 1ps

module delta_timer_queue
   import dtq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request words
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [ID_W-1:0]     req_timer_id,
   input  logic [DELTA_W-1:0]  req_interval_ticks,
   input  logic                req_repeat_flag,
   // fired timer words
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ID_W-1:0]     rsp_fired_timer,
   // register port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_RELOAD = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [CD_W-1:0]        cd_ff, cd_in;
   logic [TIE_W-1:0]       tie_ff;
   logic [CD_W-1:0]        idle_ff;
   logic [NUM_TIMERS-1:0]  listed_ff, listed_in;
   logic [NUM_TIMERS-1:0]  periodic_ff, periodic_in;
   logic [DELTA_W-1:0]     period_ff [NUM_TIMERS];
   logic                   period_we;
   logic [IDX_W-1:0]       period_addr;
   logic [DELTA_W-1:0]     period_wdata;
   // insertion walk
   logic [PTR_W-1:0]       pos_ff, pos_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [DELTA_W-1:0]     per_ff, per_in;
   logic [ID_W-1:0]        new_id_ff, new_id_in;
   logic                   fire_ff, fire_in;
   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;

   cell_cmd_type           cmd;
   entry_type              cells   [NUM_TIMERS];
   entry_type              lefts   [NUM_TIMERS];
   entry_type              rights  [NUM_TIMERS];
   logic [NUM_TIMERS:0]    seen;
   logic [NUM_TIMERS-1:0]  cell_valid;

   logic                   accept;
   logic                   id_ok;
   logic [IDX_W-1:0]       req_idx;
   logic [IDX_W-1:0]       head_idx;
   entry_type              head;
   entry_type              cur;
   logic                   at_end;
   logic [SUM_W-1:0]       sum_next;
   logic                   found;
   logic [DELTA_W-1:0]     gap;
   logic [DELTA_W-1:0]     ins_delta;
   logic [CD_W-1:0]        cd_dec;

   // saturating load of the 28-bit countdown
   function automatic logic [CD_W-1:0] sat_cd(input logic [DELTA_W-1:0] v);
      sat_cd = (|v[DELTA_W-1:CD_W]) ? CD_MAX : v[CD_W-1:0];
   endfunction

   // ---------------------------------------------------------------
   // cell chain: slot 0 is the head of the list
   // ---------------------------------------------------------------
   assign seen[0] = 1'b0;

   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign lefts[g] = '0;
      end else begin : g_mid
         assign lefts[g] = cells[g-1];
      end
      if (g == NUM_TIMERS - 1) begin : g_last
         assign rights[g] = '0;
      end else begin : g_inner
         assign rights[g] = cells[g+1];
      end

      dtq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (PTR_W'(g)),
         .cmd        (cmd),
         .left       (lefts[g]),
         .right      (rights[g]),
         .seen_in    (seen[g]),
         .seen_out   (seen[g+1]),
         .entry      (cells[g])
      );

      assign cell_valid[g] = cells[g].valid;
   end

   // ---------------------------------------------------------------
   // handshakes and register port
   // ---------------------------------------------------------------
   assign req_stall       = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept          = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fired_timer = rsp_id_ff;
   assign pready          = 1'b1;

   always_comb begin
      prdata = '0;
      if (paddr[2])
         prdata = 32'(idle_ff);
      else
         prdata = 32'(tie_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tie_ff  <= TIE_RESET;
         idle_ff <= CD_MAX;
      end else if (psel && penable && pwrite) begin
         if (paddr[2])
            idle_ff <= pwdata[CD_W-1:0];
         else
            tie_ff  <= pwdata[TIE_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // request decode and walk datapath
   // ---------------------------------------------------------------
   assign id_ok    = 32'(req_timer_id) < 32'(NUM_TIMERS);
   assign req_idx  = req_timer_id[IDX_W-1:0];
   assign head     = cells[0];
   assign head_idx = head.id[IDX_W-1:0];
   assign cd_dec   = (cd_ff == '0) ? '0 : cd_ff - CD_W'(1);

   // walk looks at one slot per cycle
   assign cur      = cells[pos_ff[IDX_W-1:0]];
   assign at_end   = (pos_ff == PTR_W'(NUM_TIMERS)) || !cur.valid;
   assign sum_next = sum_ff + SUM_W'(cur.delta);
   assign found    = !at_end && (SUM_W'(per_ff) < sum_next);
   // per >= running sum whenever the gap is used
   assign gap      = per_ff - sum_ff[DELTA_W-1:0];

   always_comb begin
      if (pos_ff == '0)
         ins_delta = per_ff;              // new head takes whole period
      else if (gap != '0)
         ins_delta = gap;
      else
         ins_delta = DELTA_W'(tie_ff);    // would tie with predecessor
   end

   always_comb begin
      state_in     = state_ff;
      cd_in        = cd_ff;
      listed_in    = listed_ff;
      periodic_in  = periodic_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      per_in       = per_ff;
      new_id_in    = new_id_ff;
      fire_in      = fire_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_id_in    = rsp_id_ff;
      period_we    = 1'b0;
      period_addr  = req_idx;
      period_wdata = req_interval_ticks;
      cmd          = '0;
      cmd.op       = CELL_NOP;

      if (rsp_valid_ff && !rsp_stall)
         rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (mode_type'(req_mode))
                  MODE_TICK: begin
                     if (cd_dec != '0) begin
                        cd_in = cd_dec;
                     end else if (!head.valid) begin
                        cd_in = idle_ff;
                     end else begin
                        // head expires: report, pop, maybe re-arm
                        cd_in              = '0;
                        rsp_valid_in       = 1'b1;
                        rsp_id_in          = head.id;
                        listed_in[head_idx] = 1'b0;
                        cmd.op             = CELL_POP;
                        if (periodic_ff[head_idx]) begin
                           listed_in[head_idx] = 1'b1;
                           per_in    = period_ff[head_idx];
                           new_id_in = head.id;
                           pos_in    = '0;
                           sum_in    = '0;
                           fire_in   = 1'b1;
                           state_in  = ST_WALK;
                        end else begin
                           state_in  = ST_RELOAD;
                        end
                     end
                  end
                  MODE_INSTALL: begin
                     if (id_ok) begin
                        period_we            = 1'b1;
                        periodic_in[req_idx] = req_repeat_flag;
                        if (!listed_ff[req_idx]) begin
                           listed_in[req_idx] = 1'b1;
                           per_in    = req_interval_ticks;
                           new_id_in = req_timer_id;
                           pos_in    = '0;
                           sum_in    = '0;
                           fire_in   = 1'b0;
                           state_in  = ST_WALK;
                        end
                     end
                  end
                  MODE_REMOVE: begin
                     if (id_ok && listed_ff[req_idx]) begin
                        listed_in[req_idx] = 1'b0;
                        cmd.op     = CELL_REMOVE;
                        cmd.target = req_timer_id;
                     end
                  end
                  MODE_SET_IV: begin
                     if (id_ok)
                        period_we = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (found || at_end) begin
               cmd.op          = CELL_INSERT;
               cmd.pos         = pos_ff;
               cmd.fresh.valid = 1'b1;
               cmd.fresh.id    = new_id_ff;
               cmd.fresh.delta = ins_delta;
               if (pos_ff == '0)
                  cd_in = sat_cd(per_ff);
               state_in = fire_ff ? ST_RELOAD : ST_IDLE;
            end else begin
               sum_in = sum_next;
               pos_in = pos_ff + PTR_W'(1);
            end
         end
         ST_RELOAD: begin
            cd_in    = head.valid ? sat_cd(head.delta) : idle_ff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cd_ff        <= CD_MAX;
         listed_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         fire_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cd_ff        <= cd_in;
         listed_ff    <= listed_in;
         rsp_valid_ff <= rsp_valid_in;
         fire_ff      <= fire_in;
      end
      periodic_ff <= periodic_in;
      pos_ff      <= pos_in;
      sum_ff      <= sum_in;
      per_ff      <= per_in;
      new_id_ff   <= new_id_in;
      rsp_id_ff   <= rsp_id_in;
      if (period_we)
         period_ff[period_addr] <= period_wdata;
   end

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   a_listed_matches_cells: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> $countones(listed_ff) == $countones(cell_valid))
      else $error("listed marks disagree with occupied cells");

   a_fire_from_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_IDLE) && $past(accept))
      else $error("result raised outside a tick");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> pos_ff <= PTR_W'(NUM_TIMERS))
      else $error("walk ran past the end of the chain");

endmodule

// File: verif/dtq_fire_checker.sv
// dtq_fire_checker: watches the request, fired-timer and register ports of the
// delta timer queue, predicts every fired timer and compares. Depends on dtq_pkg.
`timescale 1ns / 1ps

module dtq_fire_checker
   import dtq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [ID_W-1:0]     req_timer_id,
   input  logic [DELTA_W-1:0]  req_interval_ticks,
   input  logic                req_repeat_flag,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [ID_W-1:0]     rsp_fired_timer,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic                pready,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [31:0]         pwdata,
   output int                  fire_pending,
   output int                  fail_count
);

   localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_TIMERS);

   // shadow of the timer list
   logic [DELTA_W-1:0] dly [NUM_TIMERS];
   logic [DELTA_W-1:0] period [NUM_TIMERS];
   logic               periodic [NUM_TIMERS];
   logic               listed [NUM_TIMERS];
   logic [PTR_W-1:0]   fwd [NUM_TIMERS];
   logic [PTR_W-1:0]   bwd [NUM_TIMERS];
   logic [PTR_W-1:0]   first;
   logic [CD_W-1:0]    countdown;
   logic [TIE_W-1:0]   tie_ticks;
   logic [CD_W-1:0]    idle_ticks;
   logic [ID_W-1:0]    fired_q [$];

   function automatic void load_count(logic [DELTA_W-1:0] v);
      countdown = (v > DELTA_W'(CD_MAX)) ? CD_MAX : v[CD_W-1:0];
   endfunction

   // insert an unlisted timer in expiry order; returns 1 when it became head
   function automatic bit link_timer(int id);
      logic [DELTA_W-1:0] per;
      longint unsigned    sum;
      logic [DELTA_W-1:0] dt;
      int                 p;
      int                 b;
      per = period[id];
      p   = first;
      sum = 0;
      listed[id] = 1'b1;
      if (p >= NUM_TIMERS) begin
         bwd[id] = NIL;
         fwd[id] = NIL;
         dly[id] = per;
         first   = PTR_W'(id);
         return 1'b1;
      end
      for (int s = 0; s < NUM_TIMERS; s++) begin
         sum += dly[p];
         if (longint'(per) < sum) begin
            b = bwd[p];
            if (b < NUM_TIMERS) begin
               dt = DELTA_W'(longint'(dly[p]) - (sum - per));
               dly[id] = (dt != 0) ? dt : DELTA_W'(tie_ticks);
               bwd[id] = PTR_W'(b);
               fwd[b]  = PTR_W'(id);
            end else begin
               bwd[id] = NIL;
               dly[id] = per;
               first   = PTR_W'(id);
            end
            // tie near a successor floors at zero
            dly[p]  = (dly[p] >= dly[id]) ? dly[p] - dly[id] : '0;
            bwd[p]  = PTR_W'(id);
            fwd[id] = PTR_W'(p);
            return b >= NUM_TIMERS;
         end
         if (fwd[p] >= NUM_TIMERS) break;
         p = fwd[p];
      end
      dt = DELTA_W'(longint'(per) - sum);
      dly[id] = (dt != 0) ? dt : DELTA_W'(tie_ticks);
      fwd[id] = NIL;
      bwd[id] = PTR_W'(p);
      fwd[p]  = PTR_W'(id);
      return 1'b0;
   endfunction

   function automatic void unlink_timer(int id);
      int              b;
      int              f;
      longint unsigned s;
      if (!listed[id]) return;
      listed[id] = 1'b0;
      b = bwd[id];
      f = fwd[id];
      if (b < NUM_TIMERS) fwd[b] = PTR_W'(f);
      else first = (f < NUM_TIMERS) ? PTR_W'(f) : NIL;
      if (f < NUM_TIMERS) begin
         s = longint'(dly[f]) + dly[id];
         bwd[f] = (b < NUM_TIMERS) ? PTR_W'(b) : NIL;
         dly[f] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : DELTA_W'(s);
      end
   endfunction

   function automatic void predict_word(mode_type m, int id, logic [DELTA_W-1:0] iv,
                                        logic rep);
      int h;
      case (m)
         MODE_TICK: begin
            h = first;
            if (countdown != 0) countdown--;
            if (countdown != 0) return;
            if (h >= NUM_TIMERS) begin
               load_count(DELTA_W'(idle_ticks));
               return;
            end
            fired_q.push_back(ID_W'(h));
            listed[h] = 1'b0;
            first = (fwd[h] < NUM_TIMERS) ? fwd[h] : NIL;
            if (first < NUM_TIMERS) bwd[first] = NIL;
            if (periodic[h]) void'(link_timer(h));
            if (first < NUM_TIMERS) load_count(dly[first]);
            else load_count(DELTA_W'(idle_ticks));
         end
         MODE_INSTALL: begin
            period[id]   = iv;
            periodic[id] = rep;
            if (!listed[id] && link_timer(id)) load_count(dly[id]);
         end
         MODE_REMOVE: unlink_timer(id);
         default: period[id] = iv;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            listed[i] = 1'b0;
            dly[i] = '0; period[i] = '0; periodic[i] = 1'b0;
            fwd[i] = NIL; bwd[i] = NIL;
         end
         first      = NIL;
         countdown  = CD_MAX;
         tie_ticks  = TIE_RESET;
         idle_ticks = CD_MAX;
         fired_q.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_TIE) tie_ticks = pwdata[TIE_W-1:0];
            else if (paddr == ADDR_IDLE) idle_ticks = pwdata[CD_W-1:0];
         end
         if (req_valid && !req_stall)
            predict_word(mode_type'(req_mode), int'(req_timer_id), req_interval_ticks,
                         req_repeat_flag);
         if (rsp_valid && !rsp_stall) begin
            if (fired_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected fired word: timer %0d", rsp_fired_timer);
            end else begin
               if (rsp_fired_timer !== fired_q[0]) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("fired_timer mismatch: expected %0d got %0d",
                              fired_q[0], rsp_fired_timer);
               end
               void'(fired_q.pop_front());
            end
         end
      end
      fire_pending = fired_q.size();
   end

endmodule

// File: verif/delta_timer_queue_tb.sv
// delta_timer_queue_tb: stimulus and verdict for the delta timer queue.
// Depends on dtq_pkg, delta_timer_queue and dtq_fire_checker.
`timescale 1ns / 1ps

module delta_timer_queue_tb;
   import dtq_pkg::*;

   localparam int LIMIT  = 600000;   // cycles before the run is declared hung
   localparam int SETTLE = 40;       // > worst install walk plus reload

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode = MODE_TICK;
   logic [ID_W-1:0]     req_timer_id = '0;
   logic [DELTA_W-1:0]  req_interval_ticks = '0;
   logic                req_repeat_flag = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ID_W-1:0]     rsp_fired_timer;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;
   int                  fire_pending;
   int                  fail_count;
   int                  cycles = 0;
   bit                  jitter = 1'b1;  // random idling on both sides

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   delta_timer_queue uut (.*);

   dtq_fire_checker chk (.*);

   // receiver: stalls about 30% of cycles unless idling is off
   always @(posedge clock)
      rsp_stall <= jitter && ($urandom_range(99) < 30);

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // one word on the request channel; valid stays up across back-to-back words
   task automatic send_word(mode_type m, logic [ID_W-1:0] id, logic [DELTA_W-1:0] iv,
                            logic rep);
      int gap;
      gap = (jitter && $urandom_range(99) < 30) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= m;
      req_timer_id       <= id;
      req_interval_ticks <= iv;
      req_repeat_flag    <= rep;
      do @(posedge clock); while (req_stall);
   endtask

   // let the queue drain: all fired words seen, then the walk latency
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (fire_pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // setup cycle then access cycle; register written at the access edge
   task automatic reg_write(logic [ADDR_W-1:0] a, logic [31:0] d);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // mostly short periods so timers actually fire; some extremes and full range
   function automatic logic [DELTA_W-1:0] pick_interval();
      int r;
      r = $urandom_range(99);
      if (r < 75) return $urandom_range(0, 40);
      if (r < 85) return $urandom_range(41, 400);
      if (r < 90) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   task automatic random_words(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         jitter = !(i >= 120 && i < 220);   // long stretch with no idling
         r = $urandom_range(99);
         if (r < 55)
            send_word(MODE_TICK, ID_W'($urandom), $urandom, 1'($urandom));
         else if (r < 80)
            send_word(MODE_INSTALL, ID_W'($urandom), pick_interval(), 1'($urandom));
         else if (r < 93)
            send_word(MODE_REMOVE, ID_W'($urandom), $urandom, 1'($urandom));
         else
            send_word(MODE_SET_IV, ID_W'($urandom), pick_interval(), 1'($urandom));
      end
      jitter = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, ties, overflow on remove, zero period
      send_word(MODE_INSTALL, 4'd0, 32'hFFFF_FFFF, 1'b0);
      send_word(MODE_INSTALL, 4'd15, 32'hFFFF_FFFF, 1'b1);   // tie with head
      send_word(MODE_REMOVE, 4'd0, '0, 1'b0);                // successor saturates
      send_word(MODE_REMOVE, 4'd7, '0, 1'b0);                // not listed
      send_word(MODE_INSTALL, 4'd15, 32'd3, 1'b0);           // already listed
      send_word(MODE_REMOVE, 4'd15, '0, 1'b0);
      send_word(MODE_INSTALL, 4'd3, 32'd0, 1'b0);            // zero countdown
      send_word(MODE_TICK, '0, '0, 1'b0);
      send_word(MODE_INSTALL, 4'd4, 32'd5, 1'b1);
      send_word(MODE_INSTALL, 4'd5, 32'd5, 1'b0);            // tie
      send_word(MODE_INSTALL, 4'd6, 32'd2, 1'b0);            // new head
      send_word(MODE_SET_IV, 4'd4, 32'd7, 1'b0);
      repeat (12) send_word(MODE_TICK, 4'hF, 32'hFFFF_FFFF, 1'b1);
      send_word(MODE_REMOVE, 4'd4, '0, 1'b0);
      drain();

      // tie delay larger than the successor's remaining delay
      reg_write(ADDR_TIE, 32'd65535);
      reg_write(ADDR_IDLE, 32'd1);
      send_word(MODE_INSTALL, 4'd1, 32'd10, 1'b0);
      send_word(MODE_INSTALL, 4'd2, 32'd10, 1'b0);
      send_word(MODE_INSTALL, 4'd8, 32'd12, 1'b0);
      send_word(MODE_REMOVE, 4'd2, '0, 1'b0);
      random_words(350);
      drain();

      reg_write(ADDR_TIE, 32'd1);
      reg_write(ADDR_IDLE, 32'h0FFF_FFFF);
      random_words(350);
      drain();                                  // sender holds off until empty

      reg_write(ADDR_TIE, $urandom_range(1, 65535));
      reg_write(ADDR_IDLE, $urandom_range(1, 30));
      random_words(400);
      drain();

      reg_write(ADDR_TIE, 32'd80);
      reg_write(ADDR_IDLE, 32'd5);
      random_words(420);

      drain();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
design/dtq_pkg.sv
design/dtq_cell.sv
design/delta_timer_queue.sv
verif/dtq_fire_checker.sv
verif/delta_timer_queue_tb.sv
